// File: hdl/cbfc_pkg.sv
// ----------------------------------------------------------------------------
// cbfc_pkg
// Shared types, identifiers and helpers of the battery-pack frame collector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cbfc_pkg;

  // fixed frame identifiers
  localparam logic [31:0] ID_V1   = 32'd2281734144;
  localparam logic [31:0] ID_V5   = 32'd2281799680;
  localparam logic [31:0] ID_V9   = 32'd2281865216;
  localparam logic [31:0] ID_V13  = 32'd2281930752;
  localparam logic [31:0] ID_VTA  = 32'd2214625280;
  localparam logic [31:0] ID_TEMP = 32'd2415951872;
  localparam logic [31:0] ID_S    = 32'd2214756352;

  // received-flag slot of each identifier
  localparam logic [2:0] SLOT_V1   = 3'd0;
  localparam logic [2:0] SLOT_V5   = 3'd1;
  localparam logic [2:0] SLOT_V9   = 3'd2;
  localparam logic [2:0] SLOT_V13  = 3'd3;
  localparam logic [2:0] SLOT_VTA  = 3'd4;
  localparam logic [2:0] SLOT_TEMP = 3'd5;
  localparam logic [2:0] SLOT_S    = 3'd6;

  localparam int NUM_SLOTS  = 7;
  localparam int NUM_VALUES = 31;
  localparam int IDX_S      = 16;
  localparam int IDX_T      = 23;
  localparam int IDX_VT     = 27;

  localparam logic [4:0]  LAST_IDX     = 5'd30;
  localparam logic [6:0]  FULL_MASK    = 7'h7F;
  localparam logic [3:0]  MAX_LEN      = 4'd8;
  localparam logic [16:0] CUR_OFFSET   = 17'd30000;
  localparam logic [16:0] TEMP_OFFSET  = 17'd40;
  localparam logic [15:0] WINDOW_RESET = 16'd20000;
  localparam logic [15:0] ELAPSED_MAX  = 16'hFFFF;

  localparam int QUEUE_DEPTH_DEF = 2;

  // item operation codes
  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // command handed from the front to the back
  typedef struct packed {
    logic        is_tick;
    logic [2:0]  slot;
    logic [3:0]  len;
    logic [63:0] payload;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CHECK,
    BK_WALK
  } back_state_t;

  // byte k of the payload, byte 0 in the top bits
  function automatic logic [7:0] pl_byte(input logic [63:0] pl, input int unsigned k);
    pl_byte = pl[63 - 8*k -: 8];
  endfunction

  // big-endian word from bytes k and k+1
  function automatic logic [15:0] pl_word(input logic [63:0] pl, input int unsigned k);
    pl_word = {pl_byte(pl, k), pl_byte(pl, k + 1)};
  endfunction

endpackage

`default_nettype wire

// File: hdl/can_battery_frame_collector_top.sv
// ----------------------------------------------------------------------------
// can_battery_frame_collector_top
// Battery-pack frame collector: front decode, command queue, store and walk.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): one item is a received frame or a
// one millisecond tick. Frames with a bad size or an unknown identifier are
// taken and dropped. Other items enter a QUEUE_DEPTH-entry command queue;
// in_stall is high only while that queue is full.
// The back pops one command a cycle while its store sequencer is idle. A
// command that causes no release leaves it idle; one that releases moves it
// to a check state that tests the store for nonzero entries, then to a walk
// that gives 31 result items, one per cycle while out_stall is low, index 0
// to 30, last set on index 30. A release of an all-zero store gives no items.
// Result channel (out_valid / out_stall): the item sits in an output register
// and holds while out_stall is high; the walk waits, and the queue keeps
// taking items until it fills.
// Configuration (cfg_valid / cfg_ready): cfg_data writes window_ms; ready is
// always high. Write it only while the block is idle.
// Reset (rst_n, synchronous) empties the queue and the store, clears the
// flags and window counter and sets window_ms to 20000, at once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module can_battery_frame_collector_top
  import cbfc_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [15:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_operation,
  input  wire logic               in_size_ok,
  input  wire logic [31:0]        in_can_id,
  input  wire logic [3:0]         in_length,
  input  wire logic [63:0]        in_payload,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [4:0]              out_value_index,
  output logic signed [16:0]      out_value,
  output logic                    out_all_received,
  output logic [6:0]              out_received_mask,
  output logic                    out_last
);

  q_stat_t q_stat;
  cmd_t    push_cmd;
  cmd_t    head_cmd;
  logic    q_push;
  logic    q_pop;

  cbfc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_size_ok   (in_size_ok),
    .in_can_id    (in_can_id),
    .in_length    (in_length),
    .in_payload   (in_payload),
    .q_stat       (q_stat),
    .q_push       (q_push),
    .q_cmd        (push_cmd)
  );

  cbfc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .stat     (q_stat)
  );

  cbfc_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data),
    .q_stat            (q_stat),
    .q_cmd             (head_cmd),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_value_index   (out_value_index),
    .out_value         (out_value),
    .out_all_received  (out_all_received),
    .out_received_mask (out_received_mask),
    .out_last          (out_last)
  );

endmodule

`default_nettype wire

// File: hdl/cbfc_front.sv
// ----------------------------------------------------------------------------
// cbfc_front
// Accepts input items, matches the frame identifier and queues commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cbfc_front
  import cbfc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_operation,
  input  wire logic        in_size_ok,
  input  wire logic [31:0] in_can_id,
  input  wire logic [3:0]  in_length,
  input  wire logic [63:0] in_payload,
  input  wire q_stat_t     q_stat,
  output logic             q_push,
  output cmd_t             q_cmd
);

  logic       known;
  logic [2:0] slot;

  always_comb begin
    known = 1'b1;
    slot  = SLOT_V1;
    priority if (in_can_id == ID_V1)   slot = SLOT_V1;
    else if (in_can_id == ID_V5)       slot = SLOT_V5;
    else if (in_can_id == ID_V9)       slot = SLOT_V9;
    else if (in_can_id == ID_V13)      slot = SLOT_V13;
    else if (in_can_id == ID_VTA)      slot = SLOT_VTA;
    else if (in_can_id == ID_TEMP)     slot = SLOT_TEMP;
    else if (in_can_id == ID_S)        slot = SLOT_S;
    else                               known = 1'b0;
  end

  assign in_stall = q_stat.full;

  // frames that change nothing are taken and dropped here
  assign q_push = in_valid && !q_stat.full &&
                  ((in_operation == OP_TICK) || (in_size_ok && known));

  always_comb begin
    q_cmd.is_tick = (in_operation == OP_TICK);
    q_cmd.slot    = slot;
    q_cmd.len     = (in_length > MAX_LEN) ? MAX_LEN : in_length;
    q_cmd.payload = in_payload;
  end

  // clk and rst_n feed only the checks below
`ifndef SYNTHESIS
  a_push_only_open: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !in_stall)
    else $error("command pushed into a full queue");
  a_len_sat: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> q_cmd.len <= MAX_LEN)
    else $error("length not saturated");
  a_drop_unknown: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !known && (in_operation == OP_FRAME)) |-> !q_push)
    else $error("unknown frame queued");
`endif

endmodule

`default_nettype wire

// File: hdl/cbfc_queue.sv
// ----------------------------------------------------------------------------
// cbfc_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cbfc_queue
  import cbfc_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  input  wire logic pop,
  output cmd_t      head_cmd,
  output q_stat_t   stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  cmd_t          mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  assign head_cmd   = mem_r[rd_ptr_r];
  assign stat.full  = (count_r == CNT_FULL);
  assign stat.empty = (count_r == '0);

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    stat.full |-> !push || pop)
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    stat.empty |-> !pop)
    else $error("queue underflow");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("queue count out of range");
`endif

endmodule

`default_nettype wire

// File: hdl/cbfc_back.sv
// ----------------------------------------------------------------------------
// cbfc_back
// Value store, received flags and window counter; walks a release out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cbfc_back
  import cbfc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [15:0]        cfg_data,
  input  wire q_stat_t            q_stat,
  input  wire cmd_t               q_cmd,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [4:0]              out_value_index,
  output logic signed [16:0]      out_value,
  output logic                    out_all_received,
  output logic [6:0]              out_received_mask,
  output logic                    out_last
);

  back_state_t state_r, state_nxt;

  logic [16:0]           store_r [NUM_VALUES];
  logic [NUM_VALUES-1:0] nz_r;
  logic [6:0]            flags_r;
  logic [15:0]           elapsed_r;
  logic [15:0]           window_r;
  logic                  all_r;
  logic [4:0]            idx_r;

  logic                  out_valid_r;
  logic [4:0]            out_index_r;
  logic [16:0]           out_value_r;
  logic                  out_all_r;
  logic [6:0]            out_mask_r;
  logic                  out_last_r;

  logic                  frame_p, tick_p, expired, load, wipe;
  logic                  rel_req, rel_all, any_nz;
  logic [6:0]            flags_new;
  logic [NUM_VALUES-1:0] we;
  logic [16:0]           wd [NUM_VALUES];

  assign cfg_ready = 1'b1;
  assign any_nz    = |nz_r;

  // control outputs of the sequencer
  always_comb begin
    q_pop     = (state_r == BK_IDLE) && !q_stat.empty;
    frame_p   = q_pop && !q_cmd.is_tick;
    tick_p    = q_pop && q_cmd.is_tick;
    expired   = (elapsed_r >= window_r);
    flags_new = flags_r | (frame_p ? (7'(1) << q_cmd.slot) : 7'd0);
    rel_req   = (frame_p && (flags_new == FULL_MASK)) ||
                (tick_p && (expired ? (flags_r[1:0] == 2'b11)
                                    : (flags_r == FULL_MASK)));
    rel_all   = !(tick_p && expired);
    load      = (state_r == BK_WALK) && (!out_valid_r || !out_stall);
    wipe      = (tick_p && expired && (flags_r[1:0] != 2'b11)) ||
                ((state_r == BK_CHECK) && !any_nz) ||
                (load && (idx_r == LAST_IDX));
  end

  always_comb begin
    unique case (state_r)
      BK_IDLE:  state_nxt = rel_req ? BK_CHECK : BK_IDLE;
      BK_CHECK: state_nxt = any_nz ? BK_WALK : BK_IDLE;
      BK_WALK:  state_nxt = (load && (idx_r == LAST_IDX)) ? BK_IDLE : BK_WALK;
      default:  state_nxt = BK_IDLE;
    endcase
  end

  // decode of the frame into store writes
  always_comb begin
    for (int i = 0; i < NUM_VALUES; i++) begin
      wd[i] = '0;
    end
    we = '0;
    if (frame_p) begin
      for (int s = 0; s < 4; s++) begin
        for (int k = 0; k < 4; k++) begin
          if ((q_cmd.slot == 3'(s)) && (q_cmd.len >= 4'(2*k + 2))) begin
            we[4*s + k] = 1'b1;
            wd[4*s + k] = {1'b0, pl_word(q_cmd.payload, 2*k)};
          end
        end
      end
      for (int k = 0; k < 4; k++) begin
        if ((q_cmd.slot == SLOT_VTA) && (q_cmd.len >= 4'(2*k + 2))) begin
          we[IDX_VT + k] = 1'b1;
          // current channels carry an offset
          wd[IDX_VT + k] = (k % 2 == 1)
                           ? {1'b0, pl_word(q_cmd.payload, 2*k)} - CUR_OFFSET
                           : {1'b0, pl_word(q_cmd.payload, 2*k)};
        end
        if ((q_cmd.slot == SLOT_TEMP) && (q_cmd.len > 4'(k))) begin
          we[IDX_T + k] = 1'b1;
          wd[IDX_T + k] = {9'd0, pl_byte(q_cmd.payload, k)} - TEMP_OFFSET;
        end
      end
      for (int k = 0; k < 5; k++) begin
        if ((q_cmd.slot == SLOT_S) && (q_cmd.len > 4'(k))) begin
          we[IDX_S + k] = 1'b1;
          wd[IDX_S + k] = {9'd0, pl_byte(q_cmd.payload, k)};
        end
      end
      // sixth s channel is a word or a lone byte depending on length
      if (q_cmd.slot == SLOT_S) begin
        if (q_cmd.len >= 4'd7) begin
          we[IDX_S + 5] = 1'b1;
          wd[IDX_S + 5] = {1'b0, pl_word(q_cmd.payload, 5)};
        end else if (q_cmd.len == 4'd6) begin
          we[IDX_S + 5] = 1'b1;
          wd[IDX_S + 5] = {9'd0, pl_byte(q_cmd.payload, 5)};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      nz_r        <= '0;
      flags_r     <= '0;
      elapsed_r   <= '0;
      window_r    <= WINDOW_RESET;
      all_r       <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        window_r <= cfg_data;
      end
      if (wipe) begin
        nz_r      <= '0;
        flags_r   <= '0;
        elapsed_r <= '0;
      end else begin
        for (int i = 0; i < NUM_VALUES; i++) begin
          if (we[i]) begin
            nz_r[i] <= (wd[i] != '0);
          end
        end
        if (frame_p) begin
          flags_r <= flags_new;
        end
        if (tick_p && !expired && (elapsed_r != ELAPSED_MAX)) begin
          elapsed_r <= elapsed_r + 1'b1;
        end
      end
      if (rel_req) begin
        all_r <= rel_all;
      end
      if (state_r == BK_CHECK) begin
        idx_r <= '0;
      end else if (load) begin
        idx_r <= idx_r + 1'b1;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // store entries without a nonzero mark read as zero
  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_VALUES; i++) begin
      if (we[i]) begin
        store_r[i] <= wd[i];
      end
    end
    if (load) begin
      out_index_r <= idx_r;
      out_value_r <= nz_r[idx_r] ? store_r[idx_r] : 17'd0;
      out_all_r   <= all_r;
      out_mask_r  <= flags_r;
      out_last_r  <= (idx_r == LAST_IDX);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_value_index   = out_index_r;
  assign out_value         = signed'(out_value_r);
  assign out_all_received  = out_all_r;
  assign out_received_mask = out_mask_r;
  assign out_last          = out_last_r;

`ifndef SYNTHESIS
  a_walk_needs_ids01: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_WALK) |-> (flags_r[1:0] == 2'b11))
    else $error("release walk without ids 0 and 1");
  a_check_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_CHECK) |=> (state_r != BK_CHECK))
    else $error("check state held");
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_WALK) |-> (idx_r <= LAST_IDX))
    else $error("walk index out of range");
  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (out_index_r == LAST_IDX))
    else $error("last flag on wrong value");
`endif

endmodule

`default_nettype wire

// File: tb/tb_can_battery_frame_collector_top.sv
// ----------------------------------------------------------------------------
// tb_can_battery_frame_collector_top
// Checks the battery-pack frame collector against a cycle-free model of its
// store, flags and window counter. Frames and ticks go in with random gaps.
// Each released value is compared with the oldest predicted one while the
// result side stalls in random bursts. The window setting changes only while
// the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_can_battery_frame_collector_top;
  import cbfc_pkg::*;

  localparam int  DRAIN_CYCLES = 40;
  localparam real LIMIT_NS     = 5_000_000.0;

  typedef struct packed {
    logic [4:0]  value_index;
    logic [16:0] value;
    logic        all_received;
    logic [6:0]  received_mask;
    logic        is_last;
  } snap_item_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic        in_operation;
  logic        in_size_ok;
  logic [31:0] in_can_id;
  logic [3:0]  in_length;
  logic [63:0] in_payload;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [4:0]  out_value_index;
  logic signed [16:0] out_value;
  logic        out_all_received;
  logic [6:0]  out_received_mask;
  logic        out_last;

  // model state
  int          pack_values [NUM_VALUES];
  logic [6:0]  seen_ids;
  logic [15:0] elapsed_cnt;
  logic [15:0] window_cfg;
  int          closures;
  snap_item_t  snapshot_q [$];

  int          errors = 0;
  bit          no_idle = 1'b0;
  int          stall_left = 0;
  snap_item_t  exp_v;

  can_battery_frame_collector_top DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_size_ok       (in_size_ok),
    .in_can_id        (in_can_id),
    .in_length        (in_length),
    .in_payload       (in_payload),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_value_index  (out_value_index),
    .out_value        (out_value),
    .out_all_received (out_all_received),
    .out_received_mask(out_received_mask),
    .out_last         (out_last)
  );

  initial forever #6 clk = ~clk;

  initial begin
    #(LIMIT_NS);
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- model

  function automatic logic [7:0] frame_byte(input logic [63:0] pl, input int k);
    return 8'(pl >> (56 - 8 * k));
  endfunction

  function automatic int frame_word(input logic [63:0] pl, input int k);
    return int'({frame_byte(pl, k), frame_byte(pl, k + 1)});
  endfunction

  function automatic logic [31:0] slot_id(input int s);
    case (s)
      SLOT_V1:   return ID_V1;
      SLOT_V5:   return ID_V5;
      SLOT_V9:   return ID_V9;
      SLOT_V13:  return ID_V13;
      SLOT_VTA:  return ID_VTA;
      SLOT_TEMP: return ID_TEMP;
      default:   return ID_S;
    endcase
  endfunction

  function automatic void clear_window();
    foreach (pack_values[i]) pack_values[i] = 0;
    seen_ids    = '0;
    elapsed_cnt = '0;
    closures++;
  endfunction

  function automatic void release_snapshot(input logic all_ids);
    bit         any;
    snap_item_t r;
    any = 1'b0;
    foreach (pack_values[i]) if (pack_values[i] != 0) any = 1'b1;
    if (any) begin
      for (int i = 0; i < NUM_VALUES; i++) begin
        r.value_index   = 5'(i);
        r.value         = 17'(pack_values[i]);
        r.all_received  = all_ids;
        r.received_mask = seen_ids;
        r.is_last       = (i == NUM_VALUES - 1);
        snapshot_q.push_back(r);
      end
    end
    clear_window();
  endfunction

  function automatic void store_frame(input logic [31:0] id, input int len,
                                      input logic [63:0] pl);
    int slot;
    int w;
    case (id)
      ID_V1:   slot = SLOT_V1;
      ID_V5:   slot = SLOT_V5;
      ID_V9:   slot = SLOT_V9;
      ID_V13:  slot = SLOT_V13;
      ID_VTA:  slot = SLOT_VTA;
      ID_TEMP: slot = SLOT_TEMP;
      ID_S:    slot = SLOT_S;
      default: slot = -1;
    endcase
    if (slot < 0) return;
    seen_ids[slot] = 1'b1;
    if (slot < SLOT_VTA) begin
      for (int i = 0; i + 1 < len; i += 2)
        pack_values[slot * 4 + i / 2] = frame_word(pl, i);
    end else if (slot == SLOT_VTA) begin
      for (int i = 0; i + 1 < len; i += 2) begin
        w = frame_word(pl, i);
        // current words carry an offset
        if (i == 2 || i == 6) w = w - int'(CUR_OFFSET);
        pack_values[IDX_VT + i / 2] = w;
      end
    end else if (slot == SLOT_TEMP) begin
      for (int i = 0; i < 4 && i < len; i++)
        pack_values[IDX_T + i] = int'(frame_byte(pl, i)) - int'(TEMP_OFFSET);
    end else begin
      for (int i = 0; i < 5 && i < len; i++)
        pack_values[IDX_S + i] = int'(frame_byte(pl, i));
      // sixth S value is a word, or a lone byte on a six-byte frame
      if (len >= 7) pack_values[IDX_S + 5] = frame_word(pl, 5);
      else if (len == 6) pack_values[IDX_S + 5] = int'(frame_byte(pl, 5));
    end
  endfunction

  function automatic void update_pack_snapshot(input logic op, input logic size_ok,
                                               input logic [31:0] id,
                                               input logic [3:0] len,
                                               input logic [63:0] pl);
    int eff_len;
    eff_len = (len > MAX_LEN) ? int'(MAX_LEN) : int'(len);
    if (op == OP_TICK) begin
      if (elapsed_cnt >= window_cfg) begin
        if (seen_ids[1:0] == 2'b11) release_snapshot(1'b0);
        else clear_window();
      end else begin
        if (elapsed_cnt != ELAPSED_MAX) elapsed_cnt++;
        if (seen_ids == FULL_MASK) release_snapshot(1'b1);
      end
    end else if (size_ok) begin
      store_frame(id, eff_len, pl);
      if (seen_ids == FULL_MASK) release_snapshot(1'b1);
    end
  endfunction

  // ---------------------------------------------------------------- checking

  function automatic void check_field(input string name, input logic signed [31:0] want,
                                      input logic signed [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (snapshot_q.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual index %0d value %0d",
                 $time, out_value_index, out_value);
        errors++;
      end else begin
        exp_v = snapshot_q.pop_front();
        check_field("value_index", exp_v.value_index, out_value_index);
        check_field("value", $signed(exp_v.value), out_value);
        check_field("all_received", exp_v.all_received, out_all_received);
        check_field("received_mask", exp_v.received_mask, out_received_mask);
        check_field("last", exp_v.is_last, out_last);
      end
    end
  end

  // result side stalls in bursts
  always @(posedge clk) begin
    if (!rst_n || no_idle) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 14);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------- drivers

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic send_item(input logic op, input logic size_ok, input logic [31:0] id,
                           input logic [3:0] len, input logic [63:0] pl);
    if (!no_idle && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_size_ok   <= size_ok;
    in_can_id    <= id;
    in_length    <= len;
    in_payload   <= pl;
    do @(posedge clk); while (in_stall);
    update_pack_snapshot(op, size_ok, id, len, pl);
  endtask

  task automatic send_frame(input int slot, input logic [3:0] len, input logic [63:0] pl);
    send_item(OP_FRAME, 1'b1, slot_id(slot), len, pl);
  endtask

  task automatic send_tick();
    send_item(OP_TICK, 1'($urandom_range(0, 1)), $urandom, 4'($urandom_range(0, 15)),
              rand64());
  endtask

  task automatic tick_until_closed();
    int start;
    start = closures;
    do send_tick(); while (closures == start);
  endtask

  // nothing in flight before the window setting may change
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (snapshot_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(input logic [15:0] ms);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= ms;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    window_cfg = ms;
  endtask

  // ---------------------------------------------------------------- tests

  // all seven ids at the reset window, extreme bytes and words
  task automatic test_full_snapshot();
    send_frame(SLOT_V1, 4'd8, '1);
    send_frame(SLOT_V5, 4'd8, '0);
    send_frame(SLOT_V9, 4'd15, rand64());
    send_frame(SLOT_V13, 4'd8, rand64());
    send_frame(SLOT_VTA, 4'd8, 64'hFFFF_0000_0000_FFFF);
    send_frame(SLOT_TEMP, 4'd8, 64'h00FF_00FF_FFFF_FFFF);
    send_frame(SLOT_S, 4'd7, rand64());
  endtask

  // short frames write only the words and bytes they hold
  task automatic test_partial_lengths();
    send_frame(SLOT_V1, 4'd1, rand64());
    send_frame(SLOT_V5, 4'd0, rand64());
    send_frame(SLOT_V9, 4'd7, rand64());
    send_frame(SLOT_V13, 4'd2, rand64());
    send_frame(SLOT_VTA, 4'd3, rand64());
    send_frame(SLOT_TEMP, 4'd2, rand64());
    send_frame(SLOT_S, 4'd6, rand64());
  endtask

  task automatic test_dropped_frames();
    send_item(OP_FRAME, 1'b0, ID_S, 4'd8, rand64());
    send_item(OP_FRAME, 1'b1, ID_TEMP ^ 32'h1, 4'd8, rand64());
  endtask

  task automatic test_window_expiry();
    write_window(16'd1);
    // expiry with ids 0 and 1 but an empty store releases nothing
    send_frame(SLOT_V1, 4'd0, rand64());
    send_frame(SLOT_V5, 4'd0, rand64());
    tick_until_closed();
    send_frame(SLOT_V1, 4'd8, rand64());
    send_frame(SLOT_V5, 4'd8, rand64());
    tick_until_closed();
    // expiry without id 0 clears the store
    send_frame(SLOT_V13, 4'd8, rand64());
    tick_until_closed();
  endtask

  task automatic test_random_windows();
    int          kind;
    int          drop_slot;
    int          order [7];
    int          j;
    int          t;
    logic [15:0] ms;
    for (int ph = 0; ph < 8; ph++) begin
      if (ph >= 6) no_idle = 1'b1;
      t = $urandom_range(0, 7);
      if (ph == 0 || t == 0) ms = 16'hFFFF;
      else if (t == 1) ms = 16'($urandom_range(100, 65534));
      else ms = 16'($urandom_range(1, 6));
      write_window(ms);
      kind = (ms >= 16'd100) ? 0 : $urandom_range(0, 3);
      drop_slot = $urandom_range(0, 1);
      for (int k = 0; k < 7; k++) order[k] = k;
      for (int k = 6; k > 0; k--) begin
        j        = $urandom_range(0, k);
        t        = order[k];
        order[k] = order[j];
        order[j] = t;
      end
      for (int k = 0; k < 7; k++) begin
        if ($urandom_range(0, 3) == 0) begin
          case ($urandom_range(0, 3))
            0: send_item(OP_FRAME, 1'b0, slot_id($urandom_range(0, 6)),
                         4'($urandom_range(0, 15)), rand64());
            1: send_item(OP_FRAME, 1'b1, $urandom, 4'($urandom_range(0, 15)), rand64());
            2: send_item(OP_FRAME, 1'b1,
                         slot_id($urandom_range(0, 6)) ^ (32'd1 << $urandom_range(0, 31)),
                         4'($urandom_range(0, 15)), rand64());
            default: begin
              if (window_cfg >= 16'd100) send_tick();
              else send_item(OP_FRAME, 1'b0, $urandom, 4'($urandom_range(0, 15)), rand64());
            end
          endcase
        end
        t = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : int'(MAX_LEN);
        case (kind)
          0, 1: send_frame(order[k], 4'(t), rand64());
          2: begin
            if (order[k] < 2 || $urandom_range(0, 1) == 1)
              send_frame(order[k], 4'(t), rand64());
          end
          default: begin
            if (order[k] != drop_slot && $urandom_range(0, 1) == 1)
              send_frame(order[k], 4'(t), rand64());
          end
        endcase
      end
      if (kind >= 2) tick_until_closed();
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    in_valid     = 1'b0;
    in_operation = OP_FRAME;
    in_size_ok   = 1'b0;
    in_can_id    = '0;
    in_length    = '0;
    in_payload   = '0;
    closures     = 0;
    clear_window();
    window_cfg   = WINDOW_RESET;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_full_snapshot();
    test_partial_lengths();
    test_dropped_frames();
    test_window_expiry();
    test_random_windows();

    wait_idle();
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
